/* hw/rtl/sust_pkg.sv */
// ----------------------------------------------------------------------------
// sust_pkg: shared types and codes for the sorted unique set table
// Holds the command codes, the result status codes and the control word
// that the top level sends to every storage cell.
// ----------------------------------------------------------------------------
`default_nettype none

package sust_pkg;

  // Command field codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_DELETE = 1'b1;

  // Result status codes
  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_DELETED   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_EMPTY     = 3'd4,
    ST_FULL      = 3'd5
  } status_t;

  // Shift control broadcast to every cell
  typedef struct packed {
    logic open_slot;   // insert commits: cells at or above the slot move up
    logic close_slot;  // delete commits: cells at or above the match move down
  } cell_ctrl_t;

endpackage

`default_nettype wire

/* hw/rtl/sust_cell.sv */
// ----------------------------------------------------------------------------
// sust_cell: one storage cell of the sorted chain
// Holds one key, compares it against the broadcast key and, on a commit,
// takes the key, its lower neighbor's entry or its upper neighbor's entry.
// ----------------------------------------------------------------------------
`default_nettype none

module sust_cell (
  input  wire logic                 clk,
  input  wire sust_pkg::cell_ctrl_t ctrl,
  input  wire logic signed [31:0]   key,
  input  wire logic                 occupied,
  input  wire logic                 left_below,
  input  wire logic signed [31:0]   left_entry,
  input  wire logic signed [31:0]   right_entry,
  output logic signed [31:0]        entry,
  output logic                      below,
  output logic                      match
);

  // Compare the held entry against the key
  assign below = occupied && (entry < key);
  assign match = occupied && (entry == key);

  // Shift the chain; cells below the key hold their entry
  always_ff @(posedge clk) begin
    if (ctrl.open_slot && !below) begin
      entry <= left_below ? key : left_entry;
    end else if (ctrl.close_slot && !below) begin
      entry <= right_entry;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/sorted_unique_set_table.sv */
// ----------------------------------------------------------------------------
// sorted_unique_set_table: ordered set of distinct signed keys
// Inserts and deletes signed 32-bit keys in a chain of cells kept in
// ascending order; each transfer returns a status and the new entry count.
// ----------------------------------------------------------------------------
//
//   channel | ports                            | direction
//   --------+----------------------------------+----------
//   input   | in_valid, in_stall, command, value | in
//   output  | out_valid, out_stall, status, entry_count | out
//
// One item per cycle unless in_stall: every cell compares its key with the
// incoming key at once; on a commit, cells at or above it shift one place.
// The result sits in an output register; input stalls only while that
// register holds a result that the output side stalls.
// Reset empties the set at once; cell contents need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_unique_set_table #(
  parameter int CAPACITY = 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               command,
  input  wire logic signed [31:0] value,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [2:0]              status,
  output logic [6:0]              entry_count
);

  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW-1:0]             count;
  logic [CW-1:0]             count_next;
  logic signed [31:0]        entries [CAPACITY];
  logic [CAPACITY-1:0]       below_vec;
  logic [CAPACITY-1:0]       match_vec;
  sust_pkg::cell_ctrl_t      ctrl;
  sust_pkg::status_t         status_next;
  logic                      accept;
  logic                      found;
  logic                      is_empty;
  logic                      is_full;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign found    = |match_vec;
  assign is_empty = (count == '0);
  assign is_full  = (count == CW'(CAPACITY));

  // Decide the outcome and the chain move for this transfer
  always_comb begin
    ctrl        = '0;
    count_next  = count;
    status_next = sust_pkg::ST_INSERTED;
    if (command == sust_pkg::CMD_INSERT) begin
      if (found) begin
        status_next = sust_pkg::ST_DUPLICATE;
      end else if (is_full) begin
        status_next = sust_pkg::ST_FULL;
      end else begin
        status_next    = sust_pkg::ST_INSERTED;
        ctrl.open_slot = accept;
        count_next     = count + CW'(1);
      end
    end else begin
      if (is_empty) begin
        status_next = sust_pkg::ST_EMPTY;
      end else if (found) begin
        status_next     = sust_pkg::ST_DELETED;
        ctrl.close_slot = accept;
        count_next      = count - CW'(1);
      end else begin
        status_next = sust_pkg::ST_NOT_FOUND;
      end
    end
  end

  // Build the chain of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic               left_below;
    logic signed [31:0] left_entry;
    logic signed [31:0] right_entry;

    if (i == 0) begin : g_first
      assign left_below = 1'b1;
      assign left_entry = '0;
    end else begin : g_inner
      assign left_below = below_vec[i-1];
      assign left_entry = entries[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_entry = '0;
    end else begin : g_mid
      assign right_entry = entries[i+1];
    end

    sust_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .key         (value),
      .occupied    (CW'(i) < count),
      .left_below  (left_below),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .entry       (entries[i]),
      .below       (below_vec[i]),
      .match       (match_vec[i])
    );
  end

  // Advance the count and hold the result until the output side takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      status      <= status_next;
      entry_count <= 7'(count_next);
    end
  end

endmodule

`default_nettype wire
